// File: design/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg: shared types and constants of the countdown timer
// Event kinds, phase codes, queue item and pipeline snapshot, and the
// reciprocal constants used by the display conversion.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int DELTA_W  = 8;
    localparam int STAMP_W  = 32;
    localparam int REM_W    = 23;   // remaining milliseconds, max 5999000
    localparam int MIN_W    = 7;
    localparam int SEC_W    = 6;
    localparam int TSEC_W   = 13;   // remaining whole seconds, max 5999

    // event codes as they arrive on tuser
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_ADD_MIN = 3'd1;
    localparam logic [2:0] MODE_ADD_SEC = 3'd2;
    localparam logic [2:0] MODE_START   = 3'd3;
    localparam logic [2:0] MODE_PAUSE   = 3'd4;
    localparam logic [2:0] MODE_RESUME  = 3'd5;
    localparam logic [2:0] MODE_RESET   = 3'd6;

    localparam int MIN_MAX     = 99;
    localparam int SEC_MAX     = 59;
    localparam int SEC_FLOOR   = 10;
    localparam int MS_PER_SEC  = 1000;
    localparam int SEC_PER_MIN = 60;
    localparam int MS_PER_MIN  = MS_PER_SEC * SEC_PER_MIN;

    localparam logic [MIN_W-1:0] RESET_MIN = MIN_W'(5);
    localparam logic [SEC_W-1:0] RESET_SEC = SEC_W'(0);
    localparam logic [REM_W-1:0] RESET_REM =
        REM_W'((5 * SEC_PER_MIN + 0) * MS_PER_SEC);

    // x / 1000 == (x * RECIP_MS) >> RECIP_MS_SH, exact for x < 2^23
    localparam logic [23:0] RECIP_MS    = 24'd8589935;
    localparam int          RECIP_MS_SH = 33;
    // x / 60 == (x * RECIP_MIN) >> RECIP_MIN_SH, exact for x < 6000
    localparam logic [14:0] RECIP_MIN    = 15'd17477;
    localparam int          RECIP_MIN_SH = 20;

    typedef enum logic [2:0] {
        K_TICK,
        K_ADD_MIN,
        K_ADD_SEC,
        K_START,
        K_PAUSE,
        K_RESUME,
        K_RESET,
        K_IGNORE
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RUNNING,
        PH_PAUSED,
        PH_EXPIRED
    } t_phase;

    typedef struct packed {
        t_kind                      kind;
        logic signed [DELTA_W-1:0]  delta;
        logic [STAMP_W-1:0]         now;
    } t_event;

    typedef struct packed {
        logic               valid;
        t_phase             phase;
        logic [REM_W-1:0]   rem;
    } t_snap;

endpackage

// File: design/cdt_front.sv
// ----------------------------------------------------------------------------
// cdt_front: event intake
// Accepts input beats, classifies the mode code and holds events in a
// two-entry queue for the timer core.
// ----------------------------------------------------------------------------
module cdt_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [39:0]               i_s_tdata,   // delta[7:0], now_ms[39:8]
    input  logic [2:0]                i_s_tuser,   // mode[2:0]
    output logic                      o_q_valid,
    output cdt_pkg::t_event           o_q_item,
    input  logic                      i_q_pop
);
    import cdt_pkg::*;

    t_event     r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_kind      kind;
    t_event     item;
    logic       push;

    always_comb begin
        case (i_s_tuser)
            MODE_TICK:    kind = K_TICK;
            MODE_ADD_MIN: kind = K_ADD_MIN;
            MODE_ADD_SEC: kind = K_ADD_SEC;
            MODE_START:   kind = K_START;
            MODE_PAUSE:   kind = K_PAUSE;
            MODE_RESUME:  kind = K_RESUME;
            MODE_RESET:   kind = K_RESET;
            default:      kind = K_IGNORE;
        endcase
    end

    assign item.kind  = kind;
    assign item.delta = $signed(i_s_tdata[7:0]);
    assign item.now   = i_s_tdata[39:8];

    assign o_s_tready = (r_count != 2'd2);
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_q_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/cdt_core.sv
// ----------------------------------------------------------------------------
// cdt_core: timer state
// Applies one queued event per cycle to phase, settings and remaining time
// while the display pipeline advances, and hands it a snapshot of the result.
// ----------------------------------------------------------------------------
module cdt_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  cdt_pkg::t_event     i_q_item,
    output logic                o_q_pop,
    input  logic                i_adv,
    output cdt_pkg::t_snap      o_snap
);
    import cdt_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [MIN_W-1:0]   r_min,    n_min;
    logic [SEC_W-1:0]   r_sec,    n_sec;
    logic [REM_W-1:0]   r_load,   n_load;
    logic [REM_W-1:0]   r_rem,    n_rem;
    logic [STAMP_W-1:0] r_stamp,  n_stamp;
    t_snap              r_snap;

    logic                take;
    logic [STAMP_W-1:0]  elapsed;
    logic                expire;
    logic [REM_W-1:0]    tick_rem;
    logic signed [8:0]   sum_min;
    logic signed [8:0]   sum_sec;
    logic [MIN_W-1:0]    clamp_min;
    logic [SEC_W-1:0]    clamp_sec;
    logic [MIN_W-1:0]    set_min;
    logic [SEC_W-1:0]    base_sec;
    logic [SEC_W-1:0]    set_sec;
    logic [REM_W-1:0]    set_load;

    assign take    = i_adv && i_q_valid;
    assign o_q_pop = take;
    assign o_snap  = r_snap;

    // tick: wrapping elapsed time against what is left
    assign elapsed  = i_q_item.now - r_stamp;
    assign expire   = (elapsed >= STAMP_W'(r_rem));
    assign tick_rem = expire ? '0 : (r_rem - elapsed[REM_W-1:0]);

    assign sum_min = $signed({2'b00, r_min}) + 9'(i_q_item.delta);
    assign sum_sec = $signed({3'b000, r_sec}) + 9'(i_q_item.delta);

    always_comb begin
        if (sum_min[8]) begin
            clamp_min = '0;
        end else if (sum_min > 9'sd99) begin
            clamp_min = MIN_W'(MIN_MAX);
        end else begin
            clamp_min = sum_min[MIN_W-1:0];
        end
        if (sum_sec[8]) begin
            clamp_sec = '0;
        end else if (sum_sec > 9'sd59) begin
            clamp_sec = SEC_W'(SEC_MAX);
        end else begin
            clamp_sec = sum_sec[SEC_W-1:0];
        end

        set_min  = (i_q_item.kind == K_ADD_MIN) ? clamp_min : r_min;
        base_sec = (i_q_item.kind == K_ADD_SEC) ? clamp_sec : r_sec;
        // zero minutes keeps at least ten seconds
        if (set_min == '0 && base_sec < SEC_W'(SEC_FLOOR)) begin
            set_sec = SEC_W'(SEC_FLOOR);
        end else begin
            set_sec = base_sec;
        end
        set_load = REM_W'(set_min) * REM_W'(MS_PER_MIN)
                 + REM_W'(set_sec) * REM_W'(MS_PER_SEC);
    end

    always_comb begin
        n_phase = r_phase;
        n_min   = r_min;
        n_sec   = r_sec;
        n_load  = r_load;
        n_rem   = r_rem;
        n_stamp = r_stamp;
        case (i_q_item.kind)
            K_TICK: begin
                if (r_phase == PH_RUNNING) begin
                    n_stamp = i_q_item.now;
                    n_rem   = tick_rem;
                    n_phase = expire ? PH_EXPIRED : PH_RUNNING;
                end
            end
            K_ADD_MIN, K_ADD_SEC: begin
                if (r_phase == PH_IDLE) begin
                    n_min  = set_min;
                    n_sec  = set_sec;
                    n_load = set_load;
                    n_rem  = set_load;
                end
            end
            K_START: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_RUNNING;
                    n_stamp = i_q_item.now;
                end
            end
            K_PAUSE: begin
                // tick first; an expiring tick still ends paused
                if (r_phase == PH_RUNNING) begin
                    n_stamp = i_q_item.now;
                    n_rem   = tick_rem;
                    n_phase = PH_PAUSED;
                end
            end
            K_RESUME: begin
                if (r_phase == PH_PAUSED) begin
                    n_phase = PH_RUNNING;
                    n_stamp = i_q_item.now;
                end
            end
            K_RESET: begin
                n_rem   = r_load;
                n_phase = PH_IDLE;
                n_stamp = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_min        <= RESET_MIN;
            r_sec        <= RESET_SEC;
            r_load       <= RESET_REM;
            r_rem        <= RESET_REM;
            r_stamp      <= '0;
            r_snap.valid <= 1'b0;
        end else begin
            if (take) begin
                r_phase      <= n_phase;
                r_min        <= n_min;
                r_sec        <= n_sec;
                r_load       <= n_load;
                r_rem        <= n_rem;
                r_stamp      <= n_stamp;
                r_snap.phase <= n_phase;
                r_snap.rem   <= n_rem;
            end
            if (i_adv) begin
                r_snap.valid <= take;
            end
        end
    end

endmodule

// File: design/cdt_disp.sv
// ----------------------------------------------------------------------------
// cdt_disp: display conversion and output register
// Splits remaining milliseconds into minutes and seconds in three stages
// by reciprocal multiplication; the whole pipe moves when the output frees.
// ----------------------------------------------------------------------------
module cdt_disp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdt_pkg::t_snap              i_snap,
    output logic                        o_adv,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output cdt_pkg::t_phase             o_phase,
    output logic [cdt_pkg::MIN_W-1:0]   o_minutes,
    output logic [cdt_pkg::SEC_W-1:0]   o_seconds
);
    import cdt_pkg::*;

    logic               r_s2_valid;
    t_phase             r_s2_phase;
    logic [TSEC_W-1:0]  r_s2_tsec;
    logic               r_s3_valid;
    t_phase             r_s3_phase;
    logic [TSEC_W-1:0]  r_s3_tsec;
    logic [MIN_W-1:0]   r_s3_min;
    logic               r_out_valid;
    t_phase             r_out_phase;
    logic [MIN_W-1:0]   r_out_min;
    logic [SEC_W-1:0]   r_out_sec;

    logic [46:0]        prod_ms;
    logic [27:0]        prod_min;
    logic [TSEC_W-1:0]  sec_rest;

    assign o_adv = !r_out_valid || i_m_tready;

    assign prod_ms  = 47'(i_snap.rem) * 47'(RECIP_MS);
    assign prod_min = 28'(r_s2_tsec) * 28'(RECIP_MIN);
    assign sec_rest = r_s3_tsec - TSEC_W'(r_s3_min) * TSEC_W'(SEC_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_s2_valid  <= i_snap.valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s2_phase  <= i_snap.phase;
            r_s2_tsec   <= prod_ms[RECIP_MS_SH +: TSEC_W];
            r_s3_phase  <= r_s2_phase;
            r_s3_tsec   <= r_s2_tsec;
            r_s3_min    <= prod_min[RECIP_MIN_SH +: MIN_W];
            r_out_phase <= r_s3_phase;
            r_out_min   <= r_s3_min;
            r_out_sec   <= sec_rest[SEC_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_phase    = r_out_phase;
    assign o_minutes  = r_out_min;
    assign o_seconds  = r_out_sec;

endmodule

// File: design/countdown_timer_mm_ss.sv
// ----------------------------------------------------------------------------
// countdown_timer_mm_ss: minutes/seconds countdown timer
// Events (tick, add minutes, add seconds, start, pause, resume, reset) move
// the timer through idle, running, paused and expired; each event returns
// the phase and the remaining time as minutes and seconds.
//
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------------------
//  s_axis   | in  | tuser: mode[2:0]; tdata: delta[7:0], now_ms[39:8]
//  m_axis   | out | tdata: run_state[1:0], show_minutes[8:2], show_seconds[14:9]
//
// One event per cycle sustained while m_axis does not stall; an event's result
// passes queue, state update, two reciprocal multiplies and output register.
// The state update applies one event per cycle when not stalled; that sets the rate.
// Reset is synchronous, active low, and empties queue and pipeline.
// A stall on m_axis holds the pipeline; the two-entry queue then fills
// and drops s_axis tready.
// ----------------------------------------------------------------------------
module countdown_timer_mm_ss (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // delta[7:0], now_ms[39:8]
    input  logic [2:0]  i_s_axis_tuser,   // mode[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // run_state[1:0], show_minutes[8:2],
                                          // show_seconds[14:9], zero[15]
);
    import cdt_pkg::*;

    logic               q_valid;
    t_event             q_item;
    logic               q_pop;
    logic               adv;
    t_snap              snap;
    t_phase             out_phase;
    logic [MIN_W-1:0]   out_min;
    logic [SEC_W-1:0]   out_sec;

    cdt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    cdt_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_adv     (adv),
        .o_snap    (snap)
    );

    cdt_disp u_disp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap     (snap),
        .o_adv      (adv),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_phase    (out_phase),
        .o_minutes  (out_min),
        .o_seconds  (out_sec)
    );

    assign o_m_axis_tdata = {1'b0, out_sec, out_min, out_phase};

endmodule

// File: design/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker: port-level checks of the countdown timer
// Output handshake rules and display range and idle-time properties.
// ----------------------------------------------------------------------------
module cdt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata
);
    import cdt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[8:2] <= 7'd99)
                         && (o_m_axis_tdata[14:9] <= 6'd59)
                         && !o_m_axis_tdata[15])
        else $error("displayed time out of range");

    // an idle timer always holds a loaded time of at least ten seconds
    a_idle_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[1:0] == PH_IDLE)
            && (o_m_axis_tdata[8:2] == 7'd0)
        |-> (o_m_axis_tdata[14:9] >= 6'd10))
        else $error("idle time below ten seconds");

endmodule

bind countdown_timer_mm_ss cdt_checker u_cdt_checker (.*);
